@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FKLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fklr assertion failed");

// next-cycle implication
`define FKLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fklr assertion failed");

`endif

@@ hdl/fklr_pkg.sv @@
// ----------------------------------------------------------------------------
// fklr_pkg
// types and constants shared by the key latch controller, datapath and top
// ----------------------------------------------------------------------------
package fklr_pkg;

    localparam int KEY_SLOTS = 1024;
    localparam int KEY_W     = 10;
    localparam int STAMP_W   = 8;
    localparam int REL_W     = KEY_W + 1;

    localparam logic [KEY_W-1:0]   CODE_MASK   = 10'h37F;
    localparam logic [KEY_W-1:0]   F10_CODE    = 10'h059;
    localparam logic [KEY_W-1:0]   SLOT_LAST   = 10'h3FF;
    localparam logic [STAMP_W-1:0] FRAME_FIRST = 8'd1;
    localparam logic [STAMP_W-1:0] FRAME_LAST  = 8'd254;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_EVENT = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_TICK_SCAN,
        ST_VOID_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic frame_adv;
        logic scan_init;
        logic scan_tick;
        logic scan_void;
        logic count_clear;
        logic release_do;
        logic stamp_rd;
        logic press_do;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  key_up;
        logic  auto_rep;
        logic  stamp_hit;
        logic  scan_done;
        logic  clear_done;
        logic  out_free;
    } stat_t;

endpackage

@@ hdl/frame_key_latch_deferred_release_unit.sv @@
// Each input beat gives one result beat, loaded into an output register.
// A read, a release, an auto-repeat event or an unused func value goes from
// the execute state straight to the result state. A key press passes through
// the check state on its way to the result state. A frame tick walks the
// release list one entry a cycle through its memory port. A press that
// repeats within the same frame walks the list too. The walk covers the
// releases queued since the last tick, at most RELEASE_DEPTH. After reset
// the 1024-entry stamp table is cleared one entry a cycle, and the block
// takes no item until that clearing pass is done. Results sit in an output
// register, so the next item is taken while a result waits. The next result
// then holds the block until the waiting one leaves.
// ----------------------------------------------------------------------------
// frame_key_latch_deferred_release_unit
// per-key frame stamp latch with releases deferred to the next frame tick
// ----------------------------------------------------------------------------
module frame_key_latch_deferred_release_unit
#(
    parameter int RELEASE_DEPTH = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [fklr_pkg::KEY_W-1:0]     key_code,
    input  logic                           key_up,
    input  logic                           auto_repeat,
    input  logic                           shift_held,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fklr_pkg::STAMP_W-1:0]   key_stamp,
    output logic                           fullscreen_request,
    output logic                           throttle_on
);

    fklr_pkg::cmd_t  cmd;
    fklr_pkg::stat_t stat;

    fklr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fklr_datapath
    #(
        .RELEASE_DEPTH (RELEASE_DEPTH)
    )
    u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .func               (func),
        .key_code           (key_code),
        .key_up             (key_up),
        .auto_repeat        (auto_repeat),
        .shift_held         (shift_held),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .key_stamp          (key_stamp),
        .fullscreen_request (fullscreen_request),
        .throttle_on        (throttle_on)
    );

endmodule

@@ hdl/fklr_ctrl.sv @@
// ----------------------------------------------------------------------------
// fklr_ctrl
// sequencer for the key latch: clearing pass, item decode, list walks, result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fklr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  fklr_pkg::stat_t stat,
    output fklr_pkg::cmd_t  cmd
);

    fklr_pkg::state_t state_reg;
    fklr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fklr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            fklr_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = fklr_pkg::ST_IDLE;
                end
            end
            fklr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = fklr_pkg::ST_EXEC;
                end
            end
            fklr_pkg::ST_EXEC:
            begin
                case (stat.func)
                    fklr_pkg::FUNC_TICK:
                    begin
                        cmd.frame_adv = 1'b1;
                        cmd.scan_init = 1'b1;
                        state_next    = fklr_pkg::ST_TICK_SCAN;
                    end
                    fklr_pkg::FUNC_EVENT:
                    begin
                        if (stat.auto_rep)
                        begin
                            state_next = fklr_pkg::ST_RESULT;
                        end
                        else if (stat.key_up)
                        begin
                            cmd.release_do = 1'b1;
                            state_next     = fklr_pkg::ST_RESULT;
                        end
                        else
                        begin
                            cmd.stamp_rd = 1'b1;
                            state_next   = fklr_pkg::ST_CHECK;
                        end
                    end
                    fklr_pkg::FUNC_READ:
                    begin
                        cmd.stamp_rd = 1'b1;
                        state_next   = fklr_pkg::ST_RESULT;
                    end
                    default:
                    begin
                        state_next = fklr_pkg::ST_RESULT;
                    end
                endcase
            end
            fklr_pkg::ST_CHECK:
            begin
                cmd.press_do = 1'b1;
                // same-frame repeat press voids queued releases of the key
                if (stat.stamp_hit)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = fklr_pkg::ST_VOID_SCAN;
                end
                else
                begin
                    state_next = fklr_pkg::ST_RESULT;
                end
            end
            fklr_pkg::ST_TICK_SCAN:
            begin
                cmd.scan_tick = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.count_clear = 1'b1;
                    state_next      = fklr_pkg::ST_RESULT;
                end
            end
            fklr_pkg::ST_VOID_SCAN:
            begin
                cmd.scan_void = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = fklr_pkg::ST_RESULT;
                end
            end
            fklr_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = fklr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fklr_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != fklr_pkg::ST_IDLE);

    `FKLR_ASSERT_NEXT(a_accept_to_exec, in_valid && !in_stall, state_reg == fklr_pkg::ST_EXEC)
    `FKLR_ASSERT_IMP(a_load_in_result, cmd.result_load, state_reg == fklr_pkg::ST_RESULT)

endmodule

@@ hdl/fklr_datapath.sv @@
// ----------------------------------------------------------------------------
// fklr_datapath
// stamp table, release list, frame counter, throttle flag and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fklr_datapath
#(
    parameter int RELEASE_DEPTH = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  fklr_pkg::cmd_t                 cmd,
    output fklr_pkg::stat_t                stat,
    input  logic [1:0]                     func,
    input  logic [fklr_pkg::KEY_W-1:0]     key_code,
    input  logic                           key_up,
    input  logic                           auto_repeat,
    input  logic                           shift_held,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fklr_pkg::STAMP_W-1:0]   key_stamp,
    output logic                           fullscreen_request,
    output logic                           throttle_on
);

    localparam int CW = $clog2(RELEASE_DEPTH + 1);
    localparam int IW = $clog2(RELEASE_DEPTH);

    localparam int KW = fklr_pkg::KEY_W;
    localparam int SW = fklr_pkg::STAMP_W;
    localparam int RW = fklr_pkg::REL_W;

    // memories
    logic [SW-1:0] stamp_mem [fklr_pkg::KEY_SLOTS];
    logic [RW-1:0] rel_mem   [RELEASE_DEPTH];

    // captured item
    fklr_pkg::func_t func_reg;
    logic [KW-1:0]   code_reg;
    logic            up_reg;
    logic            rep_reg;
    logic            shift_reg;

    // control state
    logic [SW-1:0] frame_reg,     frame_next;
    logic          throttle_reg,  throttle_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [CW-1:0] scan_idx_reg,  scan_idx_next;
    logic          pend_reg,      pend_next;
    logic [KW-1:0] clear_idx_reg, clear_idx_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    logic          fs_reg, fs_next;
    logic [IW-1:0] pend_idx_reg;
    logic [SW-1:0] stamp_rd_reg;
    logic [RW-1:0] rel_rd_reg;
    logic [SW-1:0] key_stamp_reg;
    logic          fs_out_reg;
    logic          throttle_out_reg;

    logic [KW-1:0] key_k;
    logic          is_f10;
    logic          list_full;
    logic          scan_active;
    logic          idx_lt;
    logic          out_free;

    logic          st_we;
    logic [KW-1:0] st_waddr;
    logic [SW-1:0] st_wdata;
    logic [KW-1:0] st_raddr;

    logic          rel_we;
    logic [IW-1:0] rel_waddr;
    logic [RW-1:0] rel_wdata;
    logic          rel_re;

    assign key_k       = code_reg & fklr_pkg::CODE_MASK;
    assign is_f10      = (key_k == fklr_pkg::F10_CODE);
    assign list_full   = (count_reg == CW'(RELEASE_DEPTH));
    assign scan_active = cmd.scan_tick || cmd.scan_void;
    assign idx_lt      = (scan_idx_reg < count_reg);
    assign rel_re      = scan_active && idx_lt;
    assign out_free    = !out_valid_reg || !out_stall;

    assign stat.func       = func_reg;
    assign stat.key_up     = up_reg;
    assign stat.auto_rep   = rep_reg;
    assign stat.stamp_hit  = (stamp_rd_reg == frame_reg);
    assign stat.scan_done  = !idx_lt && !pend_reg;
    assign stat.clear_done = (clear_idx_reg == fklr_pkg::SLOT_LAST);
    assign stat.out_free   = out_free;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= fklr_pkg::func_t'(func);
            code_reg  <= key_code;
            up_reg    <= key_up;
            rep_reg   <= auto_repeat;
            shift_reg <= shift_held;
        end
    end

    // stamp table ports
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = key_k;
        st_wdata = '0;
        if (cmd.clear_step)
        begin
            st_we    = 1'b1;
            st_waddr = clear_idx_reg;
        end
        else if (cmd.scan_tick && pend_reg && rel_rd_reg[KW])
        begin
            st_we    = 1'b1;
            st_waddr = rel_rd_reg[KW-1:0];
        end
        else if (cmd.release_do && list_full)
        begin
            // no room to defer, release at once
            st_we = 1'b1;
        end
        else if (cmd.press_do)
        begin
            st_we    = 1'b1;
            st_wdata = frame_reg;
        end
    end

    assign st_raddr = (func_reg == fklr_pkg::FUNC_READ) ? code_reg : key_k;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stamp_mem[st_waddr] <= st_wdata;
        end
        if (cmd.stamp_rd)
        begin
            stamp_rd_reg <= stamp_mem[st_raddr];
        end
    end

    // release list ports, entry is {valid, key}
    always_comb
    begin
        rel_we    = 1'b0;
        rel_waddr = count_reg[IW-1:0];
        rel_wdata = {1'b1, key_k};
        if (cmd.release_do && !list_full)
        begin
            rel_we = 1'b1;
        end
        else if (cmd.scan_void && pend_reg && (rel_rd_reg[KW-1:0] == key_k))
        begin
            rel_we    = 1'b1;
            rel_waddr = pend_idx_reg;
            rel_wdata = {1'b0, key_k};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rel_we)
        begin
            rel_mem[rel_waddr] <= rel_wdata;
        end
        if (rel_re)
        begin
            rel_rd_reg   <= rel_mem[scan_idx_reg[IW-1:0]];
            pend_idx_reg <= scan_idx_reg[IW-1:0];
        end
    end

    // control next values
    always_comb
    begin
        frame_next     = frame_reg;
        throttle_next  = throttle_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = rel_re;
        clear_idx_next = clear_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        fs_next        = fs_reg;

        if (cmd.clear_step)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
        end
        if (cmd.accept)
        begin
            fs_next = 1'b0;
        end
        if (cmd.frame_adv)
        begin
            frame_next = (frame_reg == fklr_pkg::FRAME_LAST) ?
                         fklr_pkg::FRAME_FIRST : frame_reg + 1'b1;
        end
        if (cmd.scan_init)
        begin
            scan_idx_next = '0;
        end
        else if (rel_re)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (cmd.count_clear)
        begin
            count_next = '0;
        end
        else if (cmd.release_do && !list_full)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.release_do && is_f10)
        begin
            throttle_next = 1'b0;
        end
        if (cmd.press_do && is_f10)
        begin
            if (shift_reg)
            begin
                throttle_next = 1'b1;
            end
            else
            begin
                fs_next = 1'b1;
            end
        end
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= fklr_pkg::FRAME_FIRST;
            throttle_reg  <= 1'b0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            clear_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            throttle_reg  <= throttle_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            clear_idx_reg <= clear_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fs_reg <= fs_next;
        if (cmd.result_load)
        begin
            key_stamp_reg    <= (func_reg == fklr_pkg::FUNC_READ) ? stamp_rd_reg : '0;
            fs_out_reg       <= fs_reg;
            throttle_out_reg <= throttle_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign key_stamp          = key_stamp_reg;
    assign fullscreen_request = fs_out_reg;
    assign throttle_on        = throttle_out_reg;

    `FKLR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(RELEASE_DEPTH))
    `FKLR_ASSERT_IMP(a_frame_range, 1'b1, (frame_reg != '0) && (frame_reg <= fklr_pkg::FRAME_LAST))
    `FKLR_ASSERT_IMP(a_load_when_free, cmd.result_load, !out_valid_reg || !out_stall)
    `FKLR_ASSERT_NEXT(a_pend_follows_read, rel_re, pend_reg)

endmodule
